// ----- rtl/core/aging_neighbor_table_unit_defines.svh -----
// assertion macros used by the table unit
// the using scope provides clk and rst_n
`ifndef AGING_NEIGHBOR_TABLE_UNIT_DEFINES_SVH
`define AGING_NEIGHBOR_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ANB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ANB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/anb_pkg.sv -----
package anb_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ADDR_BITS_DEF   = 16;

  // fixed field widths
  localparam int REQ_W     = 2;
  localparam int NADDR_W   = 16;
  localparam int RAND_W    = 16;
  localparam int STATUS_W  = 3;
  localparam int HOP_W     = 16;
  localparam int HIDX_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int CNT_W     = 16;

  localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd60;

  typedef enum logic [REQ_W-1:0] {
    REQ_ANNOUNCE = 2'd0,
    REQ_FORWARD  = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_REFRESHED = 3'd0,
    ST_ADDED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NONE      = 3'd4,
    ST_DONE      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_ROT     = 3'd1,
    CELL_DROP    = 3'd2,
    CELL_REFRESH = 3'd3,
    CELL_APPEND  = 3'd4
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [CNT_W-1:0] timeout;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_ANN  = 3'd1,
    S_MOD  = 3'd2,
    S_TICK = 3'd3,
    S_ROT  = 3'd4
  } fsm_state_t;

endpackage

// ----- rtl/core/anb_cell.sv -----
module anb_cell import anb_pkg::*; #(
  parameter int AW  = ADDR_BITS_DEF,
  parameter int CW  = $clog2(TABLE_DEPTH_DEF + 1),
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CW-1:0]    limit,
  input  logic [AW-1:0]    key,
  input  logic [AW-1:0]    nb_addr,
  input  logic [CNT_W-1:0] nb_cnt,
  output logic [AW-1:0]    addr_o,
  output logic [CNT_W-1:0] cnt_o,
  output logic             match
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [AW-1:0]    addr_r, addr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             below;

  // limit is the fill level, or the shift threshold while dropping
  assign below  = IDX_C < limit;
  assign match  = below && (addr_r == key);
  assign addr_o = addr_r;
  assign cnt_o  = cnt_r;

  always_comb begin
    addr_nxt = addr_r;
    cnt_nxt  = cnt_r;
    case (ctl.mode)
      CELL_HOLD: begin
      end
      CELL_ROT: begin
        addr_nxt = nb_addr;
        cnt_nxt  = nb_cnt;
      end
      CELL_DROP: begin
        if (below) begin
          addr_nxt = nb_addr;
          cnt_nxt  = nb_cnt;
        end
      end
      CELL_REFRESH: begin
        if (match) begin
          cnt_nxt = ctl.timeout;
        end
      end
      CELL_APPEND: begin
        if (IDX_C == limit) begin
          addr_nxt = key;
          cnt_nxt  = ctl.timeout;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// ----- rtl/core/anb_mod.sv -----
module anb_mod import anb_pkg::*; #(
  parameter int CW = $clog2(TABLE_DEPTH_DEF + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [RAND_W-1:0] dividend,
  input  logic [CW-1:0]     divisor,
  output logic              done,
  output logic [CW-1:0]     rem
);

  localparam int BIT_W = $clog2(RAND_W);

  logic [RAND_W-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CW:0]       trial;

  // restoring remainder, one dividend bit per cycle, msb first
  assign trial = {rem_r, dvd_r[RAND_W-1]};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    bit_nxt  = bit_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      bit_nxt = BIT_W'(RAND_W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      dvd_nxt = dvd_r << 1;
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = CW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[CW-1:0];
      end
      bit_nxt = bit_r - BIT_W'(1);
      if (bit_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      bit_r  <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/core/aging_neighbor_table_unit.sv -----
// channel   direction  handshake                  word
// in        in         start high, busy low       req_type, neighbor_addr, rand_value
// out       out        out_valid, one cycle       status, next_hop, hop_index, counts
// cfg       in         cfg_valid and cfg_ready    timeout_ticks
//
// one item at a time; busy stays high until its result is registered
// announce: busy in S_ANN only; clear, forward or tick on an empty table: never busy
// forward: busy while the bit-serial remainder unit runs (one bit per cycle)
// tick: pops each occupied entry, then rotates the chain back, one step per cycle
// reset is synchronous active low and empties the table
// the result strobe cannot be held off; out_ ports keep the result until the next one
`include "aging_neighbor_table_unit_defines.svh"

module aging_neighbor_table_unit import anb_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // item channel
  input  logic                start,
  output logic                busy,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [NADDR_W-1:0]  in_neighbor_addr,
  input  logic [RAND_W-1:0]   in_rand_value,
  // result channel
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [HOP_W-1:0]    out_next_hop,
  output logic [HIDX_W-1:0]   out_hop_index,
  output logic [COUNT_W-1:0]  out_entry_count,
  output logic [COUNT_W-1:0]  out_expired_count,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CNT_W-1:0]    cfg_timeout_ticks
);

  localparam int AW   = ADDR_BITS;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  fsm_state_t state_r, state_nxt;

  logic [CW-1:0]    occ_r, occ_nxt;
  logic [CW-1:0]    kc_r, kc_nxt;       // entries kept so far in a tick
  logic [CW-1:0]    step_r, step_nxt;   // pops done, then rotation steps left
  logic [CNT_W-1:0] timeout_r;
  logic [AW-1:0]    key_r;

  logic             accept;
  req_t             req_in;

  // cell chain
  cell_ctl_t        ctl;
  logic [CW-1:0]    limit;
  logic [AW-1:0]    cell_addr [TABLE_DEPTH];
  logic [CNT_W-1:0] cell_cnt  [TABLE_DEPTH];
  logic [AW-1:0]    nb_addr   [TABLE_DEPTH];
  logic [CNT_W-1:0] nb_cnt    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_vec;
  logic             any_hit;
  logic [AW-1:0]    fb_addr;
  logic [CNT_W-1:0] fb_cnt;

  // tick bookkeeping on the head cell
  logic [CNT_W-1:0] head_cnt, dec_cnt;
  logic             keep;
  logic [CW-1:0]    kc_inc, rot_len;
  logic             tick_last;

  // remainder unit
  logic             mod_go, mod_done;
  logic [CW-1:0]    mod_rem;
  logic [IDXW-1:0]  pos;

  // result
  logic             emit;
  status_t          res_status;
  logic [HOP_W-1:0] res_hop;
  logic [HIDX_W-1:0] res_idx;
  logic [CW-1:0]    res_count, res_expired;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [HOP_W-1:0]    out_next_hop_r;
  logic [HIDX_W-1:0]   out_hop_index_r;
  logic [COUNT_W-1:0]  out_entry_count_r;
  logic [COUNT_W-1:0]  out_expired_count_r;

  assign busy      = state_r != S_IDLE;
  assign accept    = start && !busy;
  assign req_in    = req_t'(in_req_type);
  assign cfg_ready = 1'b1;

  // head of the chain: saturating decrement, entry dies when it hits zero
  assign head_cnt  = cell_cnt[0];
  assign dec_cnt   = (head_cnt == '0) ? '0 : head_cnt - CNT_W'(1);
  assign keep      = dec_cnt != '0;
  assign kc_inc    = kc_r + CW'(keep);
  assign rot_len   = DEPTH_C - kc_inc;
  assign tick_last = step_r == (occ_r - CW'(1));

  // survivors re-enter at the tail; the rotation pass leaves counts alone
  assign fb_addr = cell_addr[0];
  assign fb_cnt  = (state_r == S_TICK) ? dec_cnt : cell_cnt[0];

  assign any_hit = |match_vec;
  assign pos     = mod_rem[IDXW-1:0];

  genvar k;
  generate
    for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      if (k == TABLE_DEPTH - 1) begin : g_tail
        assign nb_addr[k] = fb_addr;
        assign nb_cnt[k]  = fb_cnt;
      end else begin : g_mid
        assign nb_addr[k] = cell_addr[k+1];
        assign nb_cnt[k]  = cell_cnt[k+1];
      end

      anb_cell #(
        .AW  (AW),
        .CW  (CW),
        .IDX (k)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .limit   (limit),
        .key     (key_r),
        .nb_addr (nb_addr[k]),
        .nb_cnt  (nb_cnt[k]),
        .addr_o  (cell_addr[k]),
        .cnt_o   (cell_cnt[k]),
        .match   (match_vec[k])
      );
    end
  endgenerate

  anb_mod #(
    .CW (CW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mod_go),
    .dividend (in_rand_value),
    .divisor  (occ_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req_in)
            REQ_ANNOUNCE: state_nxt = S_ANN;
            REQ_FORWARD:  state_nxt = (occ_r == '0) ? S_IDLE : S_MOD;
            REQ_TICK:     state_nxt = (occ_r == '0) ? S_IDLE : S_TICK;
            REQ_CLEAR:    state_nxt = S_IDLE;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_ANN: state_nxt = S_IDLE;
      S_MOD: begin
        if (mod_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (tick_last) begin
          state_nxt = (rot_len == '0) ? S_IDLE : S_ROT;
        end
      end
      S_ROT: begin
        if (step_r == CW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs: chain control, counters and the result word
  always_comb begin
    ctl.mode    = CELL_HOLD;
    ctl.timeout = timeout_r;
    limit       = occ_r;
    mod_go      = 1'b0;
    occ_nxt     = occ_r;
    kc_nxt      = kc_r;
    step_nxt    = step_r;
    emit        = 1'b0;
    res_status  = ST_DONE;
    res_hop     = '0;
    res_idx     = '0;
    res_count   = occ_r;
    res_expired = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req_in)
            REQ_ANNOUNCE: begin
            end
            REQ_FORWARD: begin
              if (occ_r == '0) begin
                emit       = 1'b1;
                res_status = ST_NONE;
              end else begin
                mod_go = 1'b1;
              end
            end
            REQ_TICK: begin
              step_nxt = '0;
              kc_nxt   = '0;
              if (occ_r == '0) begin
                emit = 1'b1;
              end
            end
            REQ_CLEAR: begin
              emit        = 1'b1;
              res_expired = occ_r;
              res_count   = '0;
              occ_nxt     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_ANN: begin
        emit = 1'b1;
        if (any_hit) begin
          ctl.mode   = CELL_REFRESH;
          res_status = ST_REFRESHED;
        end else if (occ_r < DEPTH_C) begin
          // append lands in the cell whose index equals the fill level
          ctl.mode   = CELL_APPEND;
          occ_nxt    = occ_r + CW'(1);
          res_count  = occ_r + CW'(1);
          res_status = ST_ADDED;
        end else begin
          res_status = ST_FULL;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          emit       = 1'b1;
          res_status = ST_FOUND;
          res_hop    = HOP_W'(cell_addr[pos]);
          res_idx    = HIDX_W'(pos);
        end
      end
      S_TICK: begin
        // keep: whole chain shifts, survivor enters at the tail
        // drop: only the cells below the kept group shift
        if (keep) begin
          ctl.mode = CELL_ROT;
        end else begin
          ctl.mode = CELL_DROP;
          limit    = DEPTH_C - kc_r;
        end
        kc_nxt   = kc_inc;
        step_nxt = step_r + CW'(1);
        if (tick_last) begin
          step_nxt = rot_len;
          if (rot_len == '0) begin
            emit        = 1'b1;
            occ_nxt     = kc_inc;
            res_count   = kc_inc;
            res_expired = occ_r - kc_inc;
          end
        end
      end
      S_ROT: begin
        // bring the kept group from the top of the chain back to cell 0
        ctl.mode = CELL_ROT;
        step_nxt = step_r - CW'(1);
        if (step_r == CW'(1)) begin
          emit        = 1'b1;
          occ_nxt     = kc_r;
          res_count   = kc_r;
          res_expired = occ_r - kc_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      kc_r        <= '0;
      step_r      <= '0;
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      kc_r        <= kc_nxt;
      step_r      <= step_nxt;
      out_valid_r <= emit;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_timeout_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= AW'(in_neighbor_addr);
    end
    if (emit) begin
      out_status_r        <= res_status;
      out_next_hop_r      <= res_hop;
      out_hop_index_r     <= res_idx;
      out_entry_count_r   <= COUNT_W'(res_count);
      out_expired_count_r <= COUNT_W'(res_expired);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_next_hop      = out_next_hop_r;
  assign out_hop_index     = out_hop_index_r;
  assign out_entry_count   = out_entry_count_r;
  assign out_expired_count = out_expired_count_r;

  // fill level never passes the chain length
  `ANB_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= DEPTH_C, "fill level above table depth")
  // a tick cannot keep more entries than it has popped
  `ANB_ASSERT_NOW(a_kept_bound, state_r == S_TICK, kc_r <= step_r, "kept count above pops")
  // remainder unit only finishes while a forward waits on it
  `ANB_ASSERT_NOW(a_mod_owner, mod_done, state_r == S_MOD, "remainder done outside forward")
  // a clear answers in the next cycle with an empty table
  `ANB_ASSERT_NEXT(a_clear_resp, accept && (req_in == REQ_CLEAR),
    out_valid && (out_entry_count == '0), "clear did not empty the table")

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import anb_pkg::*;

  localparam int DEPTH      = TABLE_DEPTH_DEF;
  localparam int CYCLE_CAP  = 1000000;
  localparam int PHASE_REQS = 200;
  localparam int POOL_SIZE  = 20;

  // one expected result word
  typedef struct {
    status_t           status;
    logic [HOP_W-1:0]  hop;
    logic [HIDX_W-1:0] idx;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] gone;
  } nbr_reply_t;

  // tracks the neighbor table on the side and checks every result word in order
  class neighbor_table_scoreboard;
    logic [NADDR_W-1:0] tab_addr[DEPTH];
    logic [CNT_W-1:0]   tab_life[DEPTH];
    int                 occ;
    logic [CNT_W-1:0]   timeout;
    nbr_reply_t         pending_replies[$];
    int                 errors;
    int                 checked;
    int                 req_seen[4];
    int                 status_seen[6];
    int                 aged_out;

    function new();
      occ     = 0;
      timeout = TIMEOUT_RESET;
      errors  = 0;
      checked = 0;
      aged_out = 0;
      foreach (req_seen[i]) req_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void predict_reply(req_t req, logic [NADDR_W-1:0] addr,
                                logic [RAND_W-1:0] rnd);
      nbr_reply_t r;
      bit hit;
      int kept;
      int pos;
      logic [CNT_W-1:0] life;
      r.status = ST_DONE;
      r.hop    = '0;
      r.idx    = '0;
      r.gone   = '0;
      case (req)
        REQ_ANNOUNCE: begin
          hit = 0;
          for (int k = 0; k < occ; k++) begin
            if (!hit && tab_addr[k] == addr) begin
              tab_life[k] = timeout;
              hit = 1;
            end
          end
          if (hit) begin
            r.status = ST_REFRESHED;
          end else if (occ < DEPTH) begin
            tab_addr[occ] = addr;
            tab_life[occ] = timeout;
            occ++;
            r.status = ST_ADDED;
          end else begin
            r.status = ST_FULL;
          end
        end
        REQ_FORWARD: begin
          if (occ == 0) begin
            r.status = ST_NONE;
          end else begin
            pos      = int'(rnd) % occ;
            r.status = ST_FOUND;
            r.hop    = tab_addr[pos];
            r.idx    = pos[HIDX_W-1:0];
          end
        end
        REQ_TICK: begin
          // saturating decrement, survivors slide down keeping their order
          kept = 0;
          for (int k = 0; k < occ; k++) begin
            life = tab_life[k];
            if (life != 0) life = life - 1'b1;
            if (life == 0) begin
              r.gone = r.gone + 1'b1;
            end else begin
              tab_addr[kept] = tab_addr[k];
              tab_life[kept] = life;
              kept++;
            end
          end
          occ = kept;
        end
        default: begin
          r.gone = occ[COUNT_W-1:0];
          occ    = 0;
        end
      endcase
      r.count = occ[COUNT_W-1:0];
      req_seen[req]++;
      status_seen[r.status]++;
      aged_out += r.gone;
      pending_replies.push_back(r);
    endfunction

    task report_mismatch(string field, logic [15:0] want, logic [15:0] got);
      $display("mismatch on result %0d: %s expected %0h got %0h", checked, field, want, got);
      errors++;
    endtask

    task check_reply(logic [STATUS_W-1:0] st, logic [HOP_W-1:0] hop,
                     logic [HIDX_W-1:0] idx, logic [COUNT_W-1:0] count,
                     logic [COUNT_W-1:0] gone);
      nbr_reply_t e;
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result, status", '0, 16'(st));
        return;
      end
      e = pending_replies.pop_front();
      if (st !== e.status)    report_mismatch("status", 16'(e.status), 16'(st));
      if (hop !== e.hop)      report_mismatch("next_hop", e.hop, hop);
      if (idx !== e.idx)      report_mismatch("hop_index", 16'(e.idx), 16'(idx));
      if (count !== e.count)  report_mismatch("entry_count", 16'(e.count), 16'(count));
      if (gone !== e.gone)    report_mismatch("expired_count", 16'(e.gone), 16'(gone));
      checked++;
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [REQ_W-1:0]   in_req_type = '0;
  logic [NADDR_W-1:0] in_neighbor_addr = '0;
  logic [RAND_W-1:0]  in_rand_value = '0;
  logic               out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [HOP_W-1:0]   out_next_hop;
  logic [HIDX_W-1:0]  out_hop_index;
  logic [COUNT_W-1:0] out_entry_count;
  logic [COUNT_W-1:0] out_expired_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_timeout_ticks = '0;

  neighbor_table_scoreboard sb = new();
  int                 cycle_count = 0;
  int                 timeout_writes = 0;
  logic [NADDR_W-1:0] addr_pool[POOL_SIZE];

  aging_neighbor_table_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_neighbor_addr (in_neighbor_addr),
    .in_rand_value    (in_rand_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_next_hop     (out_next_hop),
    .out_hop_index    (out_hop_index),
    .out_entry_count  (out_entry_count),
    .out_expired_count(out_expired_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_timeout_ticks(cfg_timeout_ticks)
  );

  always #1 clk = ~clk;

  // result words last exactly one cycle; sample them at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_reply(out_status, out_next_hop, out_hop_index, out_entry_count,
                     out_expired_count);
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_count,
             sb.pending_replies.size());
    $display("[aging_neighbor_table_unit] ERROR");
    $finish;
  end

  // present one request word and hold it until the block takes it;
  // start stays high into the next word unless an idle gap follows
  task send_request(req_t req, logic [NADDR_W-1:0] addr, logic [RAND_W-1:0] rnd,
                    bit allow_gap);
    int roll;
    int gap;
    in_req_type      <= req;
    in_neighbor_addr <= addr;
    in_rand_value    <= rnd;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    sb.predict_reply(req, addr, rnd);
    // mostly back to back or short gaps, now and then a long pause
    roll = $urandom_range(0, 99);
    if (!allow_gap || roll < 55) gap = 0;
    else if (roll < 90)         gap = $urandom_range(1, 3);
    else                        gap = $urandom_range(5, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block idle: every owed result word has come back
  task wait_drained();
    start <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task write_timeout(logic [CNT_W-1:0] ticks);
    cfg_timeout_ticks <= ticks;
    cfg_valid         <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    sb.timeout = ticks;
    timeout_writes++;
  endtask

  // random phase: announcements draw mostly from a small address pool so that
  // refreshes and full-table drops happen, the rest is fresh noise
  task run_phase(int reqs);
    int roll;
    bit calm;
    logic [NADDR_W-1:0] addr;
    logic [RAND_W-1:0]  rnd;
    foreach (addr_pool[i]) addr_pool[i] = 16'($urandom_range(0, 65535));
    for (int n = 0; n < reqs; n++) begin
      // every third stretch of 50 words runs with no idle gaps at all
      calm = ((n / 50) % 3) != 1;
      addr = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : 16'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (roll < 5)       rnd = '0;
      else if (roll < 10) rnd = '1;
      else                rnd = 16'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (roll < 45)      send_request(REQ_ANNOUNCE, addr, rnd, calm);
      else if (roll < 70) send_request(REQ_FORWARD, addr, rnd, calm);
      else if (roll < 97) send_request(REQ_TICK, addr, rnd, calm);
      else                send_request(REQ_CLEAR, addr, rnd, calm);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] phase_timeout[6];
    phase_timeout = '{16'd1, 16'd0, 16'hFFFF, 16'd4, 16'd2, 16'd23};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table first
    send_request(REQ_FORWARD, 16'h1234, 16'hFFFF, 0);
    send_request(REQ_TICK, 16'hFFFF, 16'h0000, 0);
    send_request(REQ_CLEAR, 16'h0000, 16'hFFFF, 0);
    // address extremes, then a refresh of the first one
    send_request(REQ_ANNOUNCE, 16'h0000, 16'h0000, 1);
    send_request(REQ_ANNOUNCE, 16'hFFFF, 16'hFFFF, 1);
    send_request(REQ_ANNOUNCE, 16'h0000, 16'h5555, 1);
    send_request(REQ_FORWARD, 16'hAAAA, 16'h0000, 1);
    send_request(REQ_FORWARD, 16'h5555, 16'hFFFF, 1);
    // fill the table to the brim with one-hot addresses
    for (int i = 0; i < DEPTH - 2; i++)
      send_request(REQ_ANNOUNCE, 16'(1 << i), 16'($urandom_range(0, 65535)), 1);
    // one more new address is dropped, last slot picked, then wipe it all
    send_request(REQ_ANNOUNCE, 16'hBEEF, 16'h0000, 1);
    send_request(REQ_FORWARD, 16'h0000, 16'hFFFF, 1);
    send_request(REQ_CLEAR, 16'hFFFF, 16'h0000, 1);

    // random phases, first on the reset timeout, then across the range
    run_phase(PHASE_REQS);
    foreach (phase_timeout[p]) begin
      wait_drained();
      write_timeout(phase_timeout[p]);
      run_phase(PHASE_REQS);
    end

    // let any stray result word show up before the verdict
    wait_drained();
    repeat (40) @(posedge clk);

    $display("covered %0d requests over %0d timeouts (%0d ann, %0d fwd, %0d tick, %0d clr)",
             sb.checked, timeout_writes + 1, sb.req_seen[REQ_ANNOUNCE],
             sb.req_seen[REQ_FORWARD], sb.req_seen[REQ_TICK], sb.req_seen[REQ_CLEAR]);
    $display("%0d added, %0d refreshed, %0d full drops, %0d hops, %0d empty, %0d removed",
             sb.status_seen[ST_ADDED], sb.status_seen[ST_REFRESHED], sb.status_seen[ST_FULL],
             sb.status_seen[ST_FOUND], sb.status_seen[ST_NONE], sb.aged_out);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("[aging_neighbor_table_unit] OK");
    end else begin
      $display("[aging_neighbor_table_unit] ERROR");
    end
    $finish;
  end

endmodule
